// ===== rtl/core/crc16fr_pkg.sv =====
// Shared types, codes and constants of the CRC-16 frame receiver.
package crc16fr_pkg;

  localparam int unsigned MAX_DATA_DEF = 16;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] TIMEOUT_RST     = 16'd50;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_TIMEOUT     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DELIVERED = 3'd1,
    EV_LEN_ERR   = 3'd2,
    EV_CRC_ERR   = 3'd3,
    EV_BUSY      = 3'd4,
    EV_TIMEOUT   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_SEQ   = 3'd2,
    PH_LEN   = 3'd3,
    PH_CMD   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CRCLO = 3'd6,
    PH_CRCHI = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CRC,
    ST_OUT,
    ST_RD,
    ST_DELIV
  } fsm_state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        byte_taken;
    logic [2:0]  event_res;
    logic [7:0]  frame_seq;
    logic [4:0]  frame_len;
    logic [7:0]  frame_cmd;
    logic [7:0]  data_value;
    logic [3:0]  data_index;
    logic        last;
    logic [15:0] ok_total;
    logic [15:0] error_total;
    logic [15:0] timeout_total;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [15:0] seed;
    logic [7:0]  data;
  } crc_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] crc;
  } crc_rsp_t;

endpackage

// ===== rtl/core/crc16_frame_receiver.sv =====
// An accepted item is registered, decided in the execute state and its result loaded into the
// output register; a SEQ, LEN, CMD or data byte first waits for the bit-serial CRC unit.
// The block takes no new item until that result is loaded: in_stall is high outside idle, and
// output stalls hold it. A delivering CRC byte of a non-empty frame reads each data byte from
// the buffer and loads one result per data byte, in index order. Synchronous active-low reset
// returns to header hunt, clears counters and mailbox, and loads the register file defaults.
module crc16_frame_receiver #(
  parameter int unsigned MAX_DATA = crc16fr_pkg::MAX_DATA_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  crc16fr_pkg::in_t                     in_data,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output crc16fr_pkg::out_t                    out_data,
  // register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crc16fr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc16fr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import crc16fr_pkg::*;

  // Length and count need to hold MAX_DATA itself; the buffer index only MAX_DATA-1.
  localparam int unsigned LEN_W = $clog2(MAX_DATA + 1);
  localparam int unsigned IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  // Receive-side frame state; everything the restart clears lives here.
  typedef struct packed {
    phase_t           phase;
    logic [7:0]       held_seq;
    logic [LEN_W-1:0] held_len;
    logic [7:0]       held_cmd;
    logic [LEN_W-1:0] data_count;
    logic [7:0]       crc_lo;
    logic [15:0]      running_crc;
  } rx_t;

  localparam rx_t RX_RESTART = '{
    phase:       PH_SYNC1,
    held_seq:    8'h00,
    held_len:    '0,
    held_cmd:    8'h00,
    data_count:  '0,
    crc_lo:      8'h00,
    running_crc: CRC_INIT
  };

  fsm_state_t       state_r, state_nxt;
  in_t              item_r;
  rx_t              rx_r, rx_nxt;
  logic             mbox_full_r, mbox_full_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [15:0]      ok_cnt_r, ok_cnt_nxt;
  logic [15:0]      err_cnt_r, err_cnt_nxt;
  logic [15:0]      tout_cnt_r, tout_cnt_nxt;
  logic [7:0]       sync_first_r;
  logic [7:0]       sync_second_r;
  logic [15:0]      timeout_limit_r;
  out_t             res_r, res_nxt;
  logic [LEN_W-1:0] dlv_len_r, dlv_len_nxt;
  logic [LEN_W-1:0] emit_idx_r, emit_idx_nxt;
  logic             out_valid_r;
  out_t             out_data_r, out_nxt;

  // Decode results of the execute step
  logic             exec_feed;
  logic [15:0]      exec_seed;
  logic             exec_wr;
  logic             exec_deliver;

  logic [15:0]      idle_inc;
  logic             tout;
  logic             slot_free;
  logic             load_single;
  logic             load_dlv;
  logic             emit_last;
  logic [7:0]       rd_data;
  crc_req_t         crc_req;
  crc_rsp_t         crc_rsp;

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  crc16fr_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (crc_req),
    .rsp   (crc_rsp)
  );

  crc16fr_data_buf #(
    .DEPTH (MAX_DATA),
    .IDX_W (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   ((state_r == ST_EXEC) && exec_wr),
    .wr_addr (rx_r.data_count[IDX_W-1:0]),
    .wr_data (item_r.rx_byte),
    .rd_en   (state_r == ST_RD),
    .rd_addr (emit_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Timeout test: a tick ages first, a byte tests the age it arrived with
  // ---------------------------------------------------------------------------
  assign idle_inc = (idle_r == TICKS_MAX) ? idle_r : idle_r + 16'd1;
  assign tout     = (rx_r.phase != PH_SYNC1) &&
                    (((item_r.action == ACT_TICK) ? idle_inc : idle_r) > timeout_limit_r);

  // ---------------------------------------------------------------------------
  // Execute step: all frame decisions for one item, taken in ST_EXEC
  // ---------------------------------------------------------------------------
  always_comb begin
    rx_nxt        = rx_r;
    mbox_full_nxt = mbox_full_r;
    idle_nxt      = idle_r;
    ok_cnt_nxt    = ok_cnt_r;
    err_cnt_nxt   = err_cnt_r;
    tout_cnt_nxt  = tout_cnt_r;
    res_nxt       = res_r;
    dlv_len_nxt   = dlv_len_r;
    exec_feed     = 1'b0;
    exec_seed     = rx_r.running_crc;
    exec_wr       = 1'b0;
    exec_deliver  = 1'b0;

    if (state_r == ST_EXEC) begin
      res_nxt      = '0;
      res_nxt.last = 1'b1;

      case (item_r.action)
        ACT_TICK: begin
          idle_nxt = idle_inc;
          if (tout) begin
            tout_cnt_nxt      = tout_cnt_r + 16'd1;
            err_cnt_nxt       = err_cnt_r + 16'd1;
            rx_nxt            = RX_RESTART;
            res_nxt.event_res = EV_TIMEOUT;
          end
        end
        ACT_RELEASE: begin
          mbox_full_nxt = 1'b0;
        end
        ACT_BYTE: begin
          idle_nxt = 16'd0;
          // Drop a stale partial frame, then treat the byte as hunting.
          if (tout) begin
            tout_cnt_nxt      = tout_cnt_r + 16'd1;
            err_cnt_nxt       = err_cnt_r + 16'd1;
            rx_nxt            = RX_RESTART;
            res_nxt.event_res = EV_TIMEOUT;
          end
          res_nxt.byte_taken = 1'b1;
          case (tout ? PH_SYNC1 : rx_r.phase)
            PH_SYNC1: begin
              res_nxt.byte_taken = 1'b0;
              if (item_r.rx_byte == sync_first_r) begin
                rx_nxt.phase       = PH_SYNC2;
                res_nxt.byte_taken = 1'b1;
              end
            end
            PH_SYNC2: begin
              // Second-byte match wins; a repeated first byte keeps the hunt alive.
              if (item_r.rx_byte == sync_second_r) begin
                rx_nxt.phase = PH_SEQ;
              end else if (item_r.rx_byte != sync_first_r) begin
                rx_nxt             = RX_RESTART;
                res_nxt.byte_taken = 1'b0;
              end
            end
            PH_SEQ: begin
              rx_nxt.held_seq = item_r.rx_byte;
              rx_nxt.phase    = PH_LEN;
              exec_feed       = 1'b1;
              exec_seed       = CRC_INIT;
            end
            PH_LEN: begin
              rx_nxt.data_count = '0;
              if ({1'b0, item_r.rx_byte} > 9'(MAX_DATA)) begin
                err_cnt_nxt       = err_cnt_r + 16'd1;
                rx_nxt            = RX_RESTART;
                res_nxt.event_res = EV_LEN_ERR;
              end else begin
                rx_nxt.held_len = LEN_W'(item_r.rx_byte);
                rx_nxt.phase    = PH_CMD;
                exec_feed       = 1'b1;
              end
            end
            PH_CMD: begin
              rx_nxt.held_cmd = item_r.rx_byte;
              rx_nxt.phase    = (rx_r.held_len == '0) ? PH_CRCLO : PH_DATA;
              exec_feed       = 1'b1;
            end
            PH_DATA: begin
              exec_wr           = 1'b1;
              exec_feed         = 1'b1;
              rx_nxt.data_count = rx_r.data_count + LEN_W'(1);
              if ((rx_r.data_count + LEN_W'(1)) >= rx_r.held_len) begin
                rx_nxt.phase = PH_CRCLO;
              end
            end
            PH_CRCLO: begin
              rx_nxt.crc_lo = item_r.rx_byte;
              rx_nxt.phase  = PH_CRCHI;
            end
            PH_CRCHI: begin
              if ({item_r.rx_byte, rx_r.crc_lo} != rx_r.running_crc) begin
                err_cnt_nxt       = err_cnt_r + 16'd1;
                res_nxt.event_res = EV_CRC_ERR;
              end else if (mbox_full_r) begin
                err_cnt_nxt       = err_cnt_r + 16'd1;
                res_nxt.event_res = EV_BUSY;
              end else begin
                // Latch the frame header for delivery before the restart clears it.
                mbox_full_nxt     = 1'b1;
                ok_cnt_nxt        = ok_cnt_r + 16'd1;
                exec_deliver      = 1'b1;
                res_nxt.event_res = EV_DELIVERED;
                res_nxt.frame_seq = rx_r.held_seq;
                res_nxt.frame_len = 5'(rx_r.held_len);
                res_nxt.frame_cmd = rx_r.held_cmd;
                dlv_len_nxt       = rx_r.held_len;
              end
              rx_nxt = RX_RESTART;
            end
            default: begin
              rx_nxt = RX_RESTART;
            end
          endcase
        end
        default: begin
          // unused action code: one empty result
        end
      endcase
    end

    if ((state_r == ST_CRC) && crc_rsp.done) begin
      rx_nxt.running_crc = crc_rsp.crc;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_feed) begin
          state_nxt = ST_CRC;
        end else if (exec_deliver && (rx_r.held_len != '0)) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CRC: begin
        if (crc_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_DELIV;
      end
      ST_DELIV: begin
        if (slot_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  assign emit_last = ((emit_idx_r + LEN_W'(1)) == dlv_len_r);

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    crc_req.start = (state_r == ST_EXEC) && exec_feed;
    crc_req.seed  = exec_seed;
    crc_req.data  = item_r.rx_byte;
    load_single   = (state_r == ST_OUT) && slot_free;
    load_dlv      = (state_r == ST_DELIV) && slot_free;

    // advance the emit index per delivered data byte
    emit_idx_nxt = emit_idx_r;
    if (state_r == ST_EXEC) begin
      emit_idx_nxt = '0;
    end else if (load_dlv) begin
      emit_idx_nxt = emit_idx_r + LEN_W'(1);
    end

    // counters already hold their post-item values here
    out_nxt               = res_r;
    out_nxt.ok_total      = ok_cnt_r;
    out_nxt.error_total   = err_cnt_r;
    out_nxt.timeout_total = tout_cnt_r;
    if (state_r == ST_DELIV) begin
      out_nxt.data_value = rd_data;
      out_nxt.data_index = 4'(emit_idx_r);
      out_nxt.last       = emit_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rx_r        <= RX_RESTART;
      mbox_full_r <= 1'b0;
      idle_r      <= 16'd0;
      ok_cnt_r    <= 16'd0;
      err_cnt_r   <= 16'd0;
      tout_cnt_r  <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_r        <= rx_nxt;
      mbox_full_r <= mbox_full_nxt;
      idle_r      <= idle_nxt;
      ok_cnt_r    <= ok_cnt_nxt;
      err_cnt_r   <= err_cnt_nxt;
      tout_cnt_r  <= tout_cnt_nxt;
      if (load_single || load_dlv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold item, pending result and delivery bookkeeping
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      item_r <= in_data;
    end
    res_r      <= res_nxt;
    dlv_len_r  <= dlv_len_nxt;
    emit_idx_r <= emit_idx_nxt;
    if (load_single || load_dlv) begin
      out_data_r <= out_nxt;
    end
  end

  // Register file; writes beyond the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r    <= SYNC_FIRST_RST;
      sync_second_r   <= SYNC_SECOND_RST;
      timeout_limit_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r    <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second_r   <= cfg_data[7:0];
        CFG_TIMEOUT:     timeout_limit_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_crc_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crc_rsp.done |-> (state_r == ST_CRC))
    else $error("crc result arrived outside the wait state");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DELIV) |-> (emit_idx_r < dlv_len_r))
    else $error("delivery index ran past the frame length");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item not executed next cycle");

  a_not_last_is_delivery: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.event_res == EV_DELIVERED))
    else $error("multi-result output outside a delivery");

  a_data_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_r.phase == PH_DATA) |-> (rx_r.data_count < rx_r.held_len))
    else $error("data phase with count at or past the length");
`endif

endmodule

// ===== rtl/core/crc16fr_crc_unit.sv =====
// Bit-serial CRC-16/MODBUS unit: folds one byte into a CRC, one bit per cycle.
module crc16fr_crc_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc16fr_pkg::crc_req_t req,
  output crc16fr_pkg::crc_rsp_t rsp
);
  import crc16fr_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] crc_step;

  // One reflected shift of the polynomial division.
  assign crc_step = crc_r[0] ? ((crc_r >> 1) ^ CRC_POLY) : (crc_r >> 1);

  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      crc_nxt  = req.seed ^ {8'h00, req.data};
      cnt_nxt  = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_step;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.crc  = crc_r;

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("crc done without a running computation");
`endif

endmodule

// ===== rtl/core/crc16fr_data_buf.sv =====
// Frame data buffer: one write port, one registered read port.
module crc16fr_data_buf #(
  parameter int unsigned DEPTH = crc16fr_pkg::MAX_DATA_DEF,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/crc16_frame_receiver_tb.sv =====
// Self-checking testbench for the CRC-16 frame receiver: random and directed items.
`timescale 1ns / 100ps

module crc16_frame_receiver_tb;
  import crc16fr_pkg::*;

  // Action code that the block has no use for; it must answer with a bare result.
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned PHASE_ITEMS    = 32;

  // Mirror of the receiver: tracks frame state, counters and the mailbox, and keeps
  // the result items still owed by the block in arrival order.
  class frame_tracker;
    out_t        owed_q[$];
    int unsigned fails;
    logic [7:0]  sync_a, sync_b;
    logic [15:0] idle_limit;
    phase_t      phase;
    logic [7:0]  seq_r, cmd_r, crc_lo_r;
    logic [4:0]  len_r, count_r;
    logic [7:0]  store [MAX_DATA_DEF];
    logic [15:0] crc_r, idle_r, ok_r, err_r, tmo_r;
    bit          boxed;

    function new();
      sync_a     = SYNC_FIRST_RST;
      sync_b     = SYNC_SECOND_RST;
      idle_limit = TIMEOUT_RST;
      boxed      = 1'b0;
      idle_r     = '0;
      ok_r       = '0;
      err_r      = '0;
      tmo_r      = '0;
      fails      = 0;
      restart();
    endfunction

    static function logic [15:0] fold(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function void restart();
      phase    = PH_SYNC1;
      seq_r    = '0;
      len_r    = '0;
      cmd_r    = '0;
      count_r  = '0;
      crc_lo_r = '0;
      crc_r    = CRC_INIT;
    endfunction

    // Drop a partial frame that sat idle past the limit.
    function bit aged_out();
      if (phase == PH_SYNC1 || idle_r <= idle_limit) return 1'b0;
      tmo_r = tmo_r + 16'd1;
      err_r = err_r + 16'd1;
      restart();
      return 1'b1;
    endfunction

    function void post(bit taken, event_t ev, logic [7:0] seq, logic [4:0] len,
                       logic [7:0] cmd, logic [7:0] val, logic [3:0] idx, bit last);
      out_t r;
      r.byte_taken    = taken;
      r.event_res     = ev;
      r.frame_seq     = seq;
      r.frame_len     = len;
      r.frame_cmd     = cmd;
      r.data_value    = val;
      r.data_index    = idx;
      r.last          = last;
      r.ok_total      = ok_r;
      r.error_total   = err_r;
      r.timeout_total = tmo_r;
      owed_q.push_back(r);
    endfunction

    function void set_reg(cfg_reg_t sel, logic [15:0] v);
      case (sel)
        CFG_SYNC_FIRST:  sync_a = v[7:0];
        CFG_SYNC_SECOND: sync_b = v[7:0];
        CFG_TIMEOUT:     idle_limit = v;
        default: ;
      endcase
    endfunction

    function void take_item(in_t it);
      logic [7:0]  b, s, c;
      logic [15:0] got;
      int unsigned n;
      bit          taken;
      event_t      ev;
      b     = it.rx_byte;
      taken = 1'b0;
      ev    = EV_NONE;
      if (it.action == ACT_TICK) begin
        if (idle_r != TICKS_MAX) idle_r = idle_r + 16'd1;
        if (aged_out()) ev = EV_TIMEOUT;
        post(1'b0, ev, '0, '0, '0, '0, '0, 1'b1);
        return;
      end
      if (it.action == ACT_RELEASE) begin
        boxed = 1'b0;
        post(1'b0, EV_NONE, '0, '0, '0, '0, '0, 1'b1);
        return;
      end
      if (it.action == ACT_UNUSED) begin
        post(1'b0, EV_NONE, '0, '0, '0, '0, '0, 1'b1);
        return;
      end
      if (aged_out()) ev = EV_TIMEOUT;
      idle_r = '0;
      case (phase)
        PH_SYNC1: begin
          if (b == sync_a) begin
            phase = PH_SYNC2;
            taken = 1'b1;
          end
        end
        PH_SYNC2: begin
          if (b == sync_b) begin
            phase = PH_SEQ;
            taken = 1'b1;
          end else if (b == sync_a) begin
            taken = 1'b1;
          end else begin
            restart();
          end
        end
        PH_SEQ: begin
          seq_r = b;
          crc_r = fold(CRC_INIT, b);
          phase = PH_LEN;
          taken = 1'b1;
        end
        PH_LEN: begin
          taken   = 1'b1;
          count_r = '0;
          if (b > MAX_DATA_DEF) begin
            err_r = err_r + 16'd1;
            restart();
            ev = EV_LEN_ERR;
          end else begin
            len_r = b[4:0];
            crc_r = fold(crc_r, b);
            phase = PH_CMD;
          end
        end
        PH_CMD: begin
          cmd_r = b;
          crc_r = fold(crc_r, b);
          phase = (len_r == 0) ? PH_CRCLO : PH_DATA;
          taken = 1'b1;
        end
        PH_DATA: begin
          if (count_r < MAX_DATA_DEF) store[count_r[3:0]] = b;
          crc_r   = fold(crc_r, b);
          count_r = count_r + 5'd1;
          if (count_r >= len_r) phase = PH_CRCLO;
          taken = 1'b1;
        end
        PH_CRCLO: begin
          crc_lo_r = b;
          phase    = PH_CRCHI;
          taken    = 1'b1;
        end
        default: begin
          got   = {b, crc_lo_r};
          taken = 1'b1;
          if (got != crc_r) begin
            err_r = err_r + 16'd1;
            ev    = EV_CRC_ERR;
          end else if (boxed) begin
            err_r = err_r + 16'd1;
            ev    = EV_BUSY;
          end else begin
            n     = len_r;
            s     = seq_r;
            c     = cmd_r;
            boxed = 1'b1;
            ok_r  = ok_r + 16'd1;
            restart();
            if (n == 0) post(1'b1, EV_DELIVERED, s, '0, c, '0, '0, 1'b1);
            for (int i = 0; i < n; i++)
              post(1'b1, EV_DELIVERED, s, 5'(n), c, store[i], 4'(i), i == n - 1);
            return;
          end
          restart();
        end
      endcase
      post(taken, ev, '0, '0, '0, '0, '0, 1'b1);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void match_result(out_t got);
      out_t want;
      if (owed_q.size() == 0) begin
        $error("result item with nothing owed: %h", got);
        fails++;
        return;
      end
      want = owed_q.pop_front();
      compare("byte_taken", want.byte_taken, got.byte_taken);
      compare("event_res", want.event_res, got.event_res);
      compare("frame_seq", want.frame_seq, got.frame_seq);
      compare("frame_len", want.frame_len, got.frame_len);
      compare("frame_cmd", want.frame_cmd, got.frame_cmd);
      compare("data_value", want.data_value, got.data_value);
      compare("data_index", want.data_index, got.data_index);
      compare("last", want.last, got.last);
      compare("ok_total", want.ok_total, got.ok_total);
      compare("error_total", want.error_total, got.error_total);
      compare("timeout_total", want.timeout_total, got.timeout_total);
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  frame_tracker tracker;
  int unsigned  send_gap_pct = 0;
  int unsigned  stall_pct    = 0;
  int unsigned  items_sent   = 0;
  int unsigned  quiet_cycles = 0;

  crc16_frame_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random, at the rate the current phase sets.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted result; count cycles in which nothing moves on any channel
  // and give up once the block has been silent far longer than any correct run allows.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.match_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("crc16_frame_receiver_tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, idling first at the phase's rate, and hold it until accepted.
  // Called at a rising edge; returns at the edge that took the item.
  task push_item(input in_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.take_item(it);
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  task send_byte(input logic [7:0] b);
    push_item({ACT_BYTE, b});
  endtask

  task send_tick();
    push_item({ACT_TICK, 8'($urandom)});
  endtask

  task send_release();
    push_item({ACT_RELEASE, 8'($urandom)});
  endtask

  // Send a whole frame with the current header bytes, random data and a CRC that is
  // right or has one bit flipped; ticks may fall between the body bytes.
  task send_frame(input logic [7:0] seq, input logic [4:0] n, input logic [7:0] cmd,
                  input bit bad_crc, input int unsigned tick_pct);
    logic [7:0]  body [$];
    logic [15:0] crc;
    body.push_back(seq);
    body.push_back({3'b000, n});
    body.push_back(cmd);
    repeat (n) body.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (body[i]) crc = frame_tracker::fold(crc, body[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    send_byte(tracker.sync_a);
    send_byte(tracker.sync_b);
    foreach (body[i]) begin
      send_byte(body[i]);
      if ($urandom_range(99) < tick_pct) send_tick();
    end
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  // One random burst: good frames half the time, plus corrupt, oversized, abandoned frames,
  // line noise, ticks, releases and unused actions.
  task random_burst();
    int unsigned pick, n, tick_pct;
    pick     = $urandom_range(99);
    tick_pct = (tracker.idle_limit != 0) ? 15 : 0;
    n        = ($urandom_range(9) == 0) ? MAX_DATA_DEF : $urandom_range(4);
    if (pick < 50) begin
      send_frame(8'($urandom), 5'(n), 8'($urandom), 1'b0, tick_pct);
      if ($urandom_range(99) < 70) send_release();
    end else if (pick < 60) begin
      send_frame(8'($urandom), 5'(n), 8'($urandom), 1'b1, tick_pct);
    end else if (pick < 67) begin
      send_byte(tracker.sync_a);
      send_byte(tracker.sync_b);
      send_byte(8'($urandom));
      send_byte(($urandom_range(3) == 0) ? 8'd17 : 8'($urandom_range(255, 17)));
    end else if (pick < 74) begin
      // abandon a frame part way; age it out when the limit is short enough
      send_byte(tracker.sync_a);
      send_byte(tracker.sync_b);
      repeat ($urandom_range(3)) send_byte(8'($urandom));
      if (tracker.idle_limit < 8) repeat (tracker.idle_limit + 1) send_tick();
    end else if (pick < 84) begin
      repeat ($urandom_range(3, 1))
        send_byte(($urandom_range(3) == 0) ? tracker.sync_a : 8'($urandom));
    end else if (pick < 91) begin
      repeat ($urandom_range(3, 1)) send_tick();
    end else if (pick < 96) begin
      send_release();
    end else begin
      push_item({ACT_UNUSED, 8'($urandom)});
    end
  endtask

  task run_random(input int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) random_burst();
  endtask

  // Drop valid, wait for every owed result, then let the pipeline drain.
  task settle();
    in_valid <= 1'b0;
    while (tracker.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; only legal while the block is idle.
  task program_regs(input logic [7:0] first, input logic [7:0] second,
                    input logic [15:0] limit);
    cfg_reg_t    sel [3];
    logic [15:0] val [3];
    sel[0] = CFG_SYNC_FIRST;
    sel[1] = CFG_SYNC_SECOND;
    sel[2] = CFG_TIMEOUT;
    val[0] = {8'h00, first};
    val[1] = {8'h00, second};
    val[2] = limit;
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= sel[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(sel[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values, no idling.
    // stray byte while hunting for the header
    send_byte(8'h00);
    // repeated first header byte resyncs; empty frame with extreme seq and cmd
    send_byte(SYNC_FIRST_RST);
    send_frame(8'hFF, 5'd0, 8'h00, 1'b0, 0);
    push_item({ACT_UNUSED, 8'hFF});
    // one data byte, broken CRC
    send_frame(8'h00, 5'd1, 8'hFF, 1'b1, 0);
    // largest length byte is over the limit
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_release();
    // leave a partial frame aging across the next register change
    send_byte(SYNC_FIRST_RST);
    send_byte(SYNC_SECOND_RST);
    send_byte(8'h01);
    send_tick();
    send_tick();
    settle();

    // Lowest limit: the first byte must drop the stale frame, then start a new one.
    program_regs(8'h00, 8'hFF, 16'd0);
    send_gap_pct = 52;
    stall_pct    = 0;
    send_byte(8'h00);
    run_random(PHASE_ITEMS);
    settle();

    program_regs(8'hFF, 8'h00, 16'd3);
    send_gap_pct = 0;
    stall_pct    = 52;
    run_random(PHASE_ITEMS);
    settle();

    // Equal header bytes: the second-byte match takes priority.
    program_regs(8'h5A, 8'h5A, 16'hFFFF);
    send_gap_pct = 10;
    stall_pct    = 10;
    run_random(PHASE_ITEMS);
    settle();

    program_regs(SYNC_FIRST_RST, SYNC_SECOND_RST, TIMEOUT_RST);
    send_gap_pct = 0;
    stall_pct    = 0;
    run_random(PHASE_ITEMS);
    settle();

    if (tracker.fails == 0) begin
      $display("crc16_frame_receiver_tb: done, clean");
    end else begin
      $display("crc16_frame_receiver_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/crc16fr_pkg.sv
rtl/core/crc16fr_crc_unit.sv
rtl/core/crc16fr_data_buf.sv
rtl/core/crc16_frame_receiver.sv
tb/crc16_frame_receiver_tb.sv
